@@ hdl/mm_pkg.sv @@
// Shared types and constants for the matrix multiplier.
package mm_pkg;

  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int PROD_W   = 35;
  localparam int M_DATA_W = 48;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A = 2'd0,
    REG_INNER  = 2'd1,
    REG_COLS_B = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_WRITE,
    ST_CALC,
    ST_DRAIN,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

@@ hdl/matrix_multiply.sv @@
// Matrix multiplier: loads A then B element by element, then streams the product.
// Each loaded element goes through accept, two divider stages and the store write.
// The element that completes B also starts the product: each product element is
// accumulated over inner_size reads on the shared multiply-accumulate, then pushed out.
// One item at a time; s_tready is low while an element or the product is in progress.
// Synchronous reset: dimensions go to 8, load count to 0; stores are not cleared.
module matrix_multiply import mm_pkg::*; #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((ELEM_WIDTH + 7) / 8)*8-1:0] s_tdata,  // element
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [M_DATA_W-1:0]                 m_tdata,  // out_row, out_col, product_value
  output logic                                m_tlast,  // last
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_W-1:0]                    cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(2 * DEPTH);
  localparam int TOT_W  = CNT_W + 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PAD_W  = M_DATA_W - ROW_W - COL_W - PROD_W;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(v);
    end
  endfunction

  state_t state, state_next;

  logic [CFG_W-1:0]      rows_a, inner_size, cols_b;
  logic [DIM_W-1:0]      m, n, p;
  logic [TOT_W-1:0]      size_a, total, lc_ext;
  logic [CNT_W-1:0]      load_count;
  logic                  in_a, in_b, job_end_now;

  logic [ELEM_WIDTH-1:0] elem;
  logic [CNT_W-1:0]      div_x;
  logic [DIM_W-1:0]      div_d;
  logic                  wr_a, wr_b, job_end;
  logic [CNT_W-1:0]      div_q;
  logic [DIM_W-1:0]      div_r;
  logic [ADDR_W-1:0]     waddr;

  logic [IDX_W-1:0]      ci, cj, ck;
  logic                  k_last, j_last, i_last, out_free;
  logic [ADDR_W-1:0]     raddr_a, raddr_b;
  logic [ELEM_WIDTH-1:0] rdata_a, rdata_b;
  logic                  we_a, we_b;

  mac_ctl_t              ctl_issue, ctl_rd;
  logic signed [PROD_W-1:0] acc;
  logic                  mac_done;

  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_col;
  logic [PROD_W-1:0]     product_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= DIM_RESET;
      inner_size <= DIM_RESET;
      cols_b     <= DIM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROWS_A: rows_a     <= cfg_data;
        REG_INNER:  inner_size <= cfg_data;
        REG_COLS_B: cols_b     <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign m      = clamp_dim(rows_a);
  assign n      = clamp_dim(inner_size);
  assign p      = clamp_dim(cols_b);
  assign size_a = TOT_W'(m) * TOT_W'(n);
  assign total  = size_a + TOT_W'(n) * TOT_W'(p);
  assign lc_ext = TOT_W'(load_count);

  assign in_a        = lc_ext < size_a;
  assign in_b        = !in_a && (lc_ext < total);
  assign job_end_now = (lc_ext + TOT_W'(1)) >= total;

  // load bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (s_tvalid && s_tready) begin
      load_count <= job_end_now ? '0 : CNT_W'(lc_ext + TOT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      elem    <= s_tdata[ELEM_WIDTH-1:0];
      div_x   <= in_a ? load_count : CNT_W'(lc_ext - size_a);
      div_d   <= in_a ? n : p;
      wr_a    <= in_a;
      wr_b    <= in_b;
      job_end <= job_end_now;
    end
  end

  mm_div #(
    .X_W   (CNT_W),
    .MAX_D (MAX_DIM)
  ) u_div (
    .clk (clk),
    .x   (div_x),
    .d   (div_d),
    .q   (div_q),
    .r   (div_r)
  );

  assign waddr = ADDR_W'(div_q) * ADDR_W'(MAX_DIM) + ADDR_W'(div_r);

  // product sequencing
  assign k_last   = DIM_W'(ck) == n - DIM_W'(1);
  assign j_last   = DIM_W'(cj) == p - DIM_W'(1);
  assign i_last   = DIM_W'(ci) == m - DIM_W'(1);
  assign out_free = !m_tvalid || m_tready;
  assign raddr_a  = ADDR_W'(ci) * ADDR_W'(MAX_DIM) + ADDR_W'(ck);
  assign raddr_b  = ADDR_W'(ck) * ADDR_W'(MAX_DIM) + ADDR_W'(cj);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_DIV1;
      ST_DIV1:  state_next = ST_DIV2;
      ST_DIV2:  state_next = ST_WRITE;
      ST_WRITE: state_next = job_end ? ST_CALC : ST_IDLE;
      ST_CALC:  if (k_last) state_next = ST_DRAIN;
      ST_DRAIN: if (mac_done) state_next = ST_PUSH;
      ST_PUSH: begin
        if (out_free) begin
          state_next = (i_last && j_last) ? ST_IDLE : ST_CALC;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    we_a      = 1'b0;
    we_b      = 1'b0;
    ctl_issue = '0;
    case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_WRITE: begin
        we_a = wr_a;
        we_b = wr_b;
      end
      ST_CALC: begin
        ctl_issue.valid = 1'b1;
        ctl_issue.first = ck == '0;
        ctl_issue.last  = k_last;
      end
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_WRITE: begin
        ci <= '0;
        cj <= '0;
        ck <= '0;
      end
      ST_CALC:  ck <= k_last ? '0 : ck + IDX_W'(1);
      ST_PUSH: begin
        if (out_free) begin
          if (j_last) begin
            cj <= '0;
            ci <= ci + IDX_W'(1);
          end else begin
            cj <= cj + IDX_W'(1);
          end
        end
      end
      default:  ;
    endcase
  end

  mm_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_WIDTH)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (elem),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mm_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_WIDTH)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (elem),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // control travels alongside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_rd <= '0;
    end else begin
      ctl_rd <= ctl_issue;
    end
  end

  mm_mac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_rd),
    .a    (rdata_a),
    .b    (rdata_b),
    .acc  (acc),
    .done (mac_done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_PUSH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUSH && out_free) begin
      out_row       <= ROW_W'(ci);
      out_col       <= COL_W'(cj);
      product_value <= acc;
      m_tlast       <= i_last && j_last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, product_value, out_col, out_row};

`ifndef SYNTHESIS
  a_load_step: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=>
      (load_count == '0) || (load_count == CNT_W'($past(load_count) + CNT_W'(1))))
    else $error("load count did not advance by one or restart");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == ST_DRAIN))
    else $error("dot product finished outside drain");

  a_write_after_div: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> ##3 (state == ST_WRITE))
    else $error("store write not three cycles after accepted item");

  a_one_store: assert property (@(posedge clk) disable iff (rst)
    (we_a || we_b) |-> !(we_a && we_b) && ($past(state, 3) == ST_IDLE))
    else $error("store write without a matching accepted item");
`endif

endmodule

@@ hdl/mm_mem.sv @@
// Single-port-write, registered-read element store.
module mm_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/mm_div.sv @@
// Two-stage divider by a small divisor: reciprocal estimate, then one correction step.
module mm_div #(
  parameter int X_W   = 7,
  parameter int MAX_D = 8,
  localparam int D_W  = $clog2(MAX_D + 1)
) (
  input  logic           clk,
  input  logic [X_W-1:0] x,
  input  logic [D_W-1:0] d,
  output logic [X_W-1:0] q,
  output logic [D_W-1:0] r
);

  logic [X_W:0]         rcp [MAX_D + 1];
  logic [2*X_W:0]       est_full;
  logic [X_W-1:0]       q_est;
  logic [X_W-1:0]       x_r;
  logic [D_W-1:0]       d_r;
  logic [X_W+D_W-1:0]   qd;
  logic [X_W-1:0]       rem;

  for (genvar g = 0; g <= MAX_D; g++) begin : g_rcp
    localparam int unsigned RV = (1 << X_W) / (g + ((g == 0) ? 1 : 0));
    assign rcp[g] = (X_W + 1)'(RV);
  end

  // floor(x * floor(2^X_W / d) / 2^X_W) is the quotient or one short of it
  assign est_full = (2 * X_W + 1)'(x) * (2 * X_W + 1)'(rcp[d]);

  always_ff @(posedge clk) begin
    q_est <= est_full[2*X_W-1:X_W];
    x_r   <= x;
    d_r   <= d;
  end

  assign qd  = (X_W + D_W)'(q_est) * (X_W + D_W)'(d_r);
  assign rem = x_r - qd[X_W-1:0];

  always_ff @(posedge clk) begin
    if (rem >= X_W'(d_r)) begin
      q <= q_est + X_W'(1);
      r <= D_W'(rem - X_W'(d_r));
    end else begin
      q <= q_est;
      r <= D_W'(rem);
    end
  end

endmodule

@@ hdl/mm_mac.sv @@
// Shared multiply-accumulate unit: registered product, then a 35-bit wrapping sum.
module mm_mac import mm_pkg::*; #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mac_ctl_t                     ctl,
  input  logic signed [ELEM_WIDTH-1:0] a,
  input  logic signed [ELEM_WIDTH-1:0] b,
  output logic signed [PROD_W-1:0]     acc,
  output logic                         done
);

  logic signed [2*ELEM_WIDTH-1:0] prod;
  logic signed [63:0]             prod_wide;
  logic signed [PROD_W-1:0]       prod_cut;
  mac_ctl_t                       ctl_p;

  assign prod_wide = 64'(prod);
  assign prod_cut  = prod_wide[PROD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p <= '0;
      done  <= 1'b0;
    end else begin
      ctl_p <= ctl;
      done  <= ctl_p.valid && ctl_p.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (ctl_p.valid) begin
      acc <= ctl_p.first ? prod_cut : acc + prod_cut;
    end
  end

endmodule
